FILE: design/ntplt_pkg.sv
package ntplt_pkg;

    // Pipeline depth of the conversion datapath
    localparam int NSTAGES = 7;

    // Configuration register indexes
    localparam logic [1:0] CFG_ZONE_HOURS = 2'd0;
    localparam logic [1:0] CFG_DST_ENABLE = 2'd1;

    // 1900-01-01 to 1970-01-01 in seconds
    localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
    localparam logic [16:0] SECS_HOUR       = 17'd3600;
    localparam logic [16:0] SECS_DAY        = 17'd86400;

    // Reciprocals: t/86400 = ((t>>7)*RECIP_675)>>35, exact for 25-bit operands
    localparam logic [25:0] RECIP_675  = 26'd50903317;
    // rem/3600 = ((rem>>4)*RECIP_225)>>21, exact for 13-bit operands
    localparam logic [13:0] RECIP_225  = 14'd9321;
    // d/1461 = (d*RECIP_1461)>>27, exact for 16-bit operands
    localparam logic [16:0] RECIP_1461 = 17'd91868;
    // w/7 = (w*RECIP_7)>>11, exact for 8-bit operands
    localparam logic [8:0]  RECIP_7    = 9'd293;

    // Day counting from 1968-03-01 in Julian four-year cycles
    localparam logic [15:0] EPOCH_SHIFT   = 16'd671;    // 1968-03-01 .. 1970-01-01
    localparam logic [15:0] DAY_2100_MAR1 = 16'd47541;  // skips the missing 2100-02-29
    localparam logic [10:0] DAYS_CYCLE    = 11'd1461;
    localparam logic [8:0]  DAYS_YEAR     = 9'd365;

    // Day-of-year boundaries, year starting March 1
    localparam logic [8:0] DOY_APR1 = 9'd31;
    localparam logic [8:0] DOY_OCT1 = 9'd214;
    localparam logic [8:0] DOY_NOV1 = 9'd245;

    // Year-relative season of a date
    typedef enum logic [1:0] {
        PER_WINTER,
        PER_MARCH,
        PER_SUMMER,
        PER_OCTOBER
    } ntplt_period_t;

    typedef struct packed {
        logic signed [4:0] zone_hours;
        logic              dst_enable;
    } ntplt_cfg_t;

endpackage

FILE: design/ntplt_pipe.sv
module ntplt_pipe import ntplt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  ntplt_cfg_t  cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_ntp_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_local_seconds,
    output logic        m_summer_applied
);

    logic [NSTAGES-1:0] v_reg;
    logic [NSTAGES-1:0] en;

    // Stage payload registers
    logic [31:0]   t0_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [15:0]   days1_reg;
    logic [16:0]   rem2_reg;
    logic [15:0]   d2_reg, d3_reg;
    logic [4:0]    hour3_reg, hour4_reg, hour5_reg;
    logic [5:0]    q3_reg, q4_reg;
    logic [1:0]    yi4_reg;
    logic [8:0]    doy4_reg;
    ntplt_period_t per5_reg;
    logic [4:0]    day5_reg;
    logic [2:0]    wd5_reg;
    logic [31:0]   out_sec_reg;
    logic          out_sum_reg;

    // Ready chain: a stage moves when it is empty or its successor moves
    always_comb begin
        en[NSTAGES-1] = !v_reg[NSTAGES-1] || m_ready;
        for (int i = NSTAGES - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NSTAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NSTAGES; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 0: epoch shift and zone offset
    logic signed [16:0] zone_sec;
    logic [31:0]        t_zoned;

    assign zone_sec = 17'(cfg.zone_hours) * $signed(SECS_HOUR);
    assign t_zoned  = s_ntp_seconds - NTP_UNIX_OFFSET + 32'(zone_sec);

    // Stage 1: day count by reciprocal multiply
    logic [50:0] days_prod;

    assign days_prod = 51'(t0_reg[31:7]) * 51'(RECIP_675);

    // Stage 2: seconds within day, shifted day count
    logic [32:0] day_secs;
    logic [15:0] d_shift;

    assign day_secs = 33'(days1_reg) * 33'(SECS_DAY);
    assign d_shift  = days1_reg + EPOCH_SHIFT + 16'(days1_reg >= DAY_2100_MAR1);

    // Stage 3: hour of day and four-year cycle index
    logic [26:0] hour_prod;
    logic [32:0] cyc_prod;

    assign hour_prod = 27'(rem2_reg[16:4]) * 27'(RECIP_225);
    assign cyc_prod  = 33'(d2_reg) * 33'(RECIP_1461);

    // Stage 4: year within cycle and day of year
    logic [16:0] cyc_days;
    logic [10:0] r_cyc;
    logic [1:0]  yi;
    logic [10:0] yr_days;

    assign cyc_days = 17'(q3_reg) * 17'(DAYS_CYCLE);
    assign r_cyc    = 11'(d3_reg - cyc_days[15:0]);

    always_comb begin
        if (r_cyc >= 11'(3 * DAYS_YEAR)) begin
            yi = 2'd3;
        end else if (r_cyc >= 11'(2 * DAYS_YEAR)) begin
            yi = 2'd2;
        end else if (r_cyc >= 11'(DAYS_YEAR)) begin
            yi = 2'd1;
        end else begin
            yi = 2'd0;
        end
        yr_days = 11'(yi) * 11'(DAYS_YEAR);
    end

    // Stage 5: season, day of month, last-Sunday weekday term
    // 5*Y/4 mod 7 = (5*q + yi + 3) mod 7 since Y = 1968 + 4*q + yi
    ntplt_period_t per;
    logic [4:0]    day_m;
    logic [7:0]    w;
    logic [16:0]   w_prod;
    logic [5:0]    w_q;
    logic [7:0]    w_q7;

    always_comb begin
        if (doy4_reg < DOY_APR1) begin
            per = PER_MARCH;
        end else if (doy4_reg < DOY_OCT1) begin
            per = PER_SUMMER;
        end else if (doy4_reg < DOY_NOV1) begin
            per = PER_OCTOBER;
        end else begin
            per = PER_WINTER;
        end
        // March uses +4, October +1, on top of the epoch term 3
        if (per == PER_MARCH) begin
            day_m = 5'(doy4_reg + 9'd1);
            w     = 8'(q4_reg) * 8'd5 + 8'(yi4_reg) + 8'd7;
        end else begin
            day_m = 5'(doy4_reg - (DOY_OCT1 - 9'd1));
            w     = 8'(q4_reg) * 8'd5 + 8'(yi4_reg) + 8'd4;
        end
        w_prod = 17'(w) * 17'(RECIP_7);
        w_q    = w_prod[16:11];
        w_q7   = {w_q[4:0], 3'b000} - 8'(w_q);
    end

    // Stage 6: transition hour compare and summer hour
    logic [4:0]         wk;
    logic [9:0]         thr_base;
    logic [9:0]         now;
    logic signed [11:0] thr;
    logic signed [11:0] now_s;
    logic               summer;

    always_comb begin
        wk       = 5'd31 - 5'(wd5_reg);
        thr_base = {1'b0, wk, 4'b0000} + {2'b00, wk, 3'b000};
        now      = 10'(hour5_reg) + {1'b0, day5_reg, 4'b0000} + {2'b00, day5_reg, 3'b000};
        thr      = $signed({2'b00, thr_base}) + 12'sd1 + 12'(cfg.zone_hours);
        now_s    = $signed({2'b00, now});
        case (per5_reg)
            PER_SUMMER:  summer = 1'b1;
            PER_MARCH:   summer = (now_s >= thr);
            PER_OCTOBER: summer = (now_s < thr);
            default:     summer = 1'b0;
        endcase
        summer = summer && cfg.dst_enable;
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t0_reg <= t_zoned;
        end
        if (en[1]) begin
            t1_reg    <= t0_reg;
            days1_reg <= days_prod[50:35];
        end
        if (en[2]) begin
            t2_reg   <= t1_reg;
            rem2_reg <= 17'(t1_reg - day_secs[31:0]);
            d2_reg   <= d_shift;
        end
        if (en[3]) begin
            t3_reg    <= t2_reg;
            hour3_reg <= hour_prod[25:21];
            q3_reg    <= cyc_prod[32:27];
            d3_reg    <= d2_reg;
        end
        if (en[4]) begin
            t4_reg    <= t3_reg;
            hour4_reg <= hour3_reg;
            q4_reg    <= q3_reg;
            yi4_reg   <= yi;
            doy4_reg  <= 9'(r_cyc - yr_days);
        end
        if (en[5]) begin
            t5_reg    <= t4_reg;
            hour5_reg <= hour4_reg;
            per5_reg  <= per;
            day5_reg  <= day_m;
            wd5_reg   <= 3'(w - w_q7);
        end
        if (en[6]) begin
            out_sec_reg <= t5_reg + (summer ? 32'(SECS_HOUR) : 32'd0);
            out_sum_reg <= summer;
        end
    end

    assign m_local_seconds  = out_sec_reg;
    assign m_summer_applied = out_sum_reg;

endmodule

FILE: design/ntp_timestamp_to_local_time_top.sv
// NTP seconds to local Unix time. Each transaction on s_ carries the 32-bit
// NTP transmit seconds; the block removes the 1900-to-1970 offset, adds the
// signed zone in whole hours and, with dst_enable set, adds one hour between
// the last Sundays of March and October (European rule, weekday found by the
// closed-form formula). All arithmetic wraps modulo 2^32. Configuration is
// written through cfg_ (index 0 zone_hours, 1 dst_enable, others ignored)
// while no transaction is in flight. The datapath is a seven-stage pipeline
// built around constant-reciprocal multipliers: it accepts one transaction
// per cycle while m_ready is held high and presents the results on m_ in
// order; a stalled output holds the pipeline without loss.
module ntp_timestamp_to_local_time_top import ntplt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_ntp_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_local_seconds,
    output logic        m_summer_applied
);

    ntplt_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zone_hours <= '0;
            cfg_reg.dst_enable <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ZONE_HOURS: cfg_reg.zone_hours <= $signed(cfg_data);
                CFG_DST_ENABLE: cfg_reg.dst_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    ntplt_pipe u_pipe (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ntp_seconds    (s_ntp_seconds),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_local_seconds  (m_local_seconds),
        .m_summer_applied (m_summer_applied)
    );

endmodule

FILE: verif/ntp_timestamp_to_local_time_top_tb.sv
module ntp_timestamp_to_local_time_top_tb;
    import ntplt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MONTH_MARCH = 3;
    localparam int MONTH_OCTOBER = 10;
    // Indexes with no register behind them
    localparam logic [1:0] CFG_RSVD2 = 2'd2;
    localparam logic [1:0] CFG_RSVD3 = 2'd3;

    typedef struct {
        logic [31:0] ntp_seconds;
        logic [31:0] local_seconds;
        logic        summer_applied;
    } local_time_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_ntp_seconds = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_local_seconds;
    logic        m_summer_applied;

    // Copy of the configuration registers
    logic signed [4:0] zone_mirror = '0;
    logic              dst_mirror = 1'b0;

    local_time_t pending_local_times[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold_cycles = 0;

    ntp_timestamp_to_local_time_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ntp_seconds   (s_ntp_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_local_seconds (m_local_seconds),
        .m_summer_applied(m_summer_applied)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Calendar helpers
    function automatic bit leap_year(input int unsigned year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned year,
                                                 input int unsigned month);
        case (month)
            2: return leap_year(year) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    // Unix seconds at 00:00 of the given date
    function automatic logic [31:0] unix_of(input int unsigned year,
                                            input int unsigned month,
                                            input int unsigned day);
        longint unsigned days;
        int unsigned yr;
        int unsigned mo;
        days = 0;
        for (yr = 1970; yr < year; yr++) days += leap_year(yr) ? 366 : 365;
        for (mo = 1; mo < month; mo++) days += month_length(year, mo);
        days += day - 1;
        return 32'(days * 86400);
    endfunction

    // Day of the last Sunday of March or October per the closed-form weekday rule
    function automatic int last_sunday(input int unsigned year, input int unsigned month);
        int y;
        y = year;
        return 31 - (5 * y / 4 + (month == MONTH_MARCH ? 4 : 1)) % 7;
    endfunction

    // NTP seconds that map to the given zoned local value under the current zone
    function automatic logic [31:0] ntp_of_local(input logic [31:0] loc_secs);
        int z;
        z = zone_mirror;
        return loc_secs - 32'(z * 3600) + NTP_UNIX_OFFSET;
    endfunction

    // Expected local time for one timestamp under the current configuration
    function automatic local_time_t predict_local_time(input logic [31:0] ntp);
        local_time_t r;
        logic [31:0] t;
        int z;
        int unsigned days;
        int unsigned year;
        int unsigned month;
        int hour;
        int day;
        int now;
        int y;
        logic summer;
        z = zone_mirror;
        t = ntp - NTP_UNIX_OFFSET;
        t = t + 32'(z * 3600);
        summer = 1'b0;
        if (dst_mirror) begin
            days = t / 86400;
            hour = (t % 86400) / 3600;
            year = 1970;
            while (days >= (leap_year(year) ? 366 : 365)) begin
                days -= leap_year(year) ? 366 : 365;
                year++;
            end
            month = 1;
            while (month < 12 && days >= month_length(year, month)) begin
                days -= month_length(year, month);
                month++;
            end
            day = days + 1;
            y = year;
            now = hour + 24 * day;
            if (month > MONTH_MARCH && month < MONTH_OCTOBER)
                summer = 1'b1;
            else if (month == MONTH_MARCH)
                summer = (now >= 1 + z + 24 * (31 - (5 * y / 4 + 4) % 7));
            else if (month == MONTH_OCTOBER)
                summer = (now < 1 + z + 24 * (31 - (5 * y / 4 + 1) % 7));
        end
        if (summer) t = t + 32'(SECS_HOUR);
        r.ntp_seconds = ntp;
        r.local_seconds = t;
        r.summer_applied = summer;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Result checker
    always @(posedge aclk) begin
        local_time_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_local_times.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_local_seconds));
            end else begin
                e = pending_local_times.pop_front();
                if (m_local_seconds !== e.local_seconds)
                    report_mismatch($sformatf("ntp %h: local_seconds %h, want %h",
                        e.ntp_seconds, m_local_seconds, e.local_seconds));
                if (m_summer_applied !== e.summer_applied)
                    report_mismatch($sformatf("ntp %h: summer_applied %b, want %b",
                        e.ntp_seconds, m_summer_applied, e.summer_applied));
            end
        end
    end

    // Receiver: random stalls plus an optional long hold-off
    initial begin
        int hold_len;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold_len = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ntp_timestamp_to_local_time_top_tb: errors");
        $finish;
    end

    // One register write; cfg_valid stays high for the caller to drop
    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ZONE_HOURS: zone_mirror = data;
            CFG_DST_ENABLE: dst_mirror = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int zone, input bit dst);
        write_reg(CFG_ZONE_HOURS, 5'(zone));
        write_reg(CFG_DST_ENABLE, {4'($urandom), dst});
        cfg_valid <= 1'b0;
    endtask

    // Offer one timestamp, with an optional idle burst first
    task automatic send_ntp(input logic [31:0] ntp);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ntp_seconds <= ntp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_local_times.push_back(predict_local_time(ntp));
    endtask

    // Timestamp near a summer time switch, delta seconds from it
    task automatic send_near_switch(input int unsigned year, input int unsigned month,
                                    input int delta);
        int z;
        z = zone_mirror;
        send_ntp(ntp_of_local(unix_of(year, month, last_sunday(year, month))
                              + 32'((1 + z) * 3600) + 32'(delta)));
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (pending_local_times.size() != 0) @(posedge aclk);
        repeat (NSTAGES + 4) @(posedge aclk);
    endtask

    // Offset removal only, reset configuration
    task automatic test_plain_offset();
        send_ntp(32'h0000_0000);
        send_ntp(32'hFFFF_FFFF);
        send_ntp(NTP_UNIX_OFFSET);
        send_ntp(NTP_UNIX_OFFSET - 32'd1);
        send_ntp(32'h8000_0000);
        wait_results_done();
    endtask

    // Zone at both 5-bit extremes, and writes to unused indexes
    task automatic test_zone_extremes();
        configure(-16, 1'b0);
        send_ntp(32'h0000_0000);
        send_ntp(32'hFFFF_FFFF);
        wait_results_done();
        configure(15, 1'b0);
        send_ntp(32'h0000_0000);
        send_ntp(NTP_UNIX_OFFSET);
        wait_results_done();
        write_reg(CFG_RSVD2, 5'h1F);
        write_reg(CFG_RSVD3, 5'h11);
        cfg_valid <= 1'b0;
        send_ntp(32'hDEAD_BEEF);
        wait_results_done();
    endtask

    // Both switch instants, in and out of season, with zoned thresholds
    task automatic test_summer_rule();
        configure(0, 1'b1);
        send_near_switch(2024, MONTH_MARCH, -1);
        send_near_switch(2024, MONTH_MARCH, 0);
        send_near_switch(2024, MONTH_OCTOBER, -1);
        send_near_switch(2024, MONTH_OCTOBER, 0);
        send_ntp(ntp_of_local(unix_of(2050, 7, 15)));
        send_ntp(ntp_of_local(unix_of(2050, 1, 15)));
        wait_results_done();
        configure(-12, 1'b1);
        send_near_switch(1999, MONTH_MARCH, -1);
        send_near_switch(1999, MONTH_MARCH, 0);
        wait_results_done();
        configure(14, 1'b1);
        send_near_switch(2087, MONTH_OCTOBER, -1);
        send_near_switch(2087, MONTH_OCTOBER, 0);
        wait_results_done();
    endtask

    // Century non-leap year, leap day, end of range and pre-1970 wrap
    task automatic test_calendar_edges();
        configure(0, 1'b1);
        send_ntp(ntp_of_local(unix_of(2100, 3, 1) - 32'd1));
        send_ntp(ntp_of_local(unix_of(2100, 3, 1)));
        send_ntp(ntp_of_local(unix_of(2024, 2, 29) + 32'd43200));
        send_ntp(ntp_of_local(32'hFFFF_FFFF));
        send_ntp(32'd1000);
        wait_results_done();
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_output_stall();
        configure(2, 1'b1);
        tx_idle = 1'b0;
        rx_hold_cycles = 150;
        repeat (40) send_ntp($urandom);
        wait_results_done();
        tx_idle = 1'b1;
    endtask

    // Random traffic over several configurations; last phase runs without idling
    task automatic test_random_traffic();
        int phase_zone[7] = '{0, -16, 15, -12, 14, 5, -3};
        bit phase_dst[7] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        int p;
        int i;
        int unsigned yr;
        int unsigned mo;
        int delta;
        for (p = 0; p < 7; p++) begin
            configure(phase_zone[p], phase_dst[p]);
            tx_idle = (p != 6) && (p != 2);
            rx_idle = (p != 6) && (p != 3);
            for (i = 0; i < 190; i++) begin
                yr = $urandom_range(1970, 2105);
                delta = int'($urandom_range(0, 14400)) - 7200;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        mo = $urandom_range(0, 1) ? MONTH_MARCH : MONTH_OCTOBER;
                        send_near_switch(yr, mo, delta);
                    end
                    4, 5: begin
                        // around a month change
                        mo = $urandom_range(1, 12);
                        send_ntp(ntp_of_local(unix_of(yr, mo, month_length(yr, mo))
                                              + 32'd86400 + 32'(delta)));
                    end
                    default: send_ntp($urandom);
                endcase
            end
            wait_results_done();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plain_offset();
        test_zone_extremes();
        test_summer_rule();
        test_calendar_edges();
        test_output_stall();
        test_random_traffic();
        wait_results_done();
        if (mismatch_count == 0)
            $display("ntp_timestamp_to_local_time_top_tb: clean");
        else
            $display("ntp_timestamp_to_local_time_top_tb: errors");
        $finish;
    end

endmodule
